// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the time-indexed log search.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== src/tils_pkg.sv =====
// Package of the time-indexed log search: field widths, opcodes and status codes.
// Depends on nothing; used by time_indexed_log_search.
`default_nettype none

package tils_pkg;

  localparam int TIME_W    = 64;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 1024;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_LO_BIN  = 3'd1;
  localparam logic [OP_W-1:0] OP_UP_BIN  = 3'd2;
  localparam logic [OP_W-1:0] OP_LO_LIN  = 3'd3;
  localparam logic [OP_W-1:0] OP_UP_LIN  = 3'd4;
  localparam logic [OP_W-1:0] OP_LO_EST  = 3'd5;
  localparam logic [OP_W-1:0] OP_UP_EST  = 3'd6;
  localparam logic [OP_W-1:0] OP_INVALID = 3'd7;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_PUSHED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD    = 2'd3;

endpackage

`default_nettype wire

// ===== src/time_indexed_log_search.sv =====
// Time-indexed log search: one synchronous 64-bit time memory, a sequencer and a
// radix-2 divider. A push or a rejected query goes straight to the result; binary
// search halves the range per memory read; linear scan reads one entry per step;
// estimate may first divide to guess where its scan starts. One item is worked at a
// time: a new item is taken only while the sequencer is idle.
// Reset empties the store and clears the limit.
`default_nettype none

module time_indexed_log_search #(
  parameter int DEPTH = tils_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tils_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tils_pkg::OP_W-1:0]    opcode,
  input  wire logic [tils_pkg::TIME_W-1:0]  key_time,
  input  wire logic [tils_pkg::IDX_W-1:0]   start_index,
  input  wire logic [tils_pkg::IDX_W-1:0]   end_index,
  input  wire logic [tils_pkg::TIME_W-1:0]  step_time,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tils_pkg::IDX_W-1:0]        found_index,
  output logic [tils_pkg::ST_W-1:0]         status
);
  import tils_pkg::*;
`include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int XW = IDX_W + 1;
  localparam int DCW = $clog2(TIME_W);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_BIN   = 15'b000000000000010,
    S_BINW  = 15'b000000000000100,
    S_BEND  = 15'b000000000001000,
    S_FWD   = 15'b000000000010000,
    S_FWDW  = 15'b000000000100000,
    S_E0W   = 15'b000000001000000,
    S_DIV   = 15'b000000010000000,
    S_ECHK  = 15'b000000100000000,
    S_ECHKW = 15'b000001000000000,
    S_BWD   = 15'b000010000000000,
    S_BWDW  = 15'b000100000000000,
    S_UPD   = 15'b001000000000000,
    S_UPDW  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;

  logic [CW-1:0]     cnt;
  logic [CFG_W-1:0]  max_entries;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] key, step;
  logic [IDX_W-1:0]  lo, hi, it, best, res;
  logic [XW-1:0]     a, b;
  logic [ST_W-1:0]   res_st;
  logic [TIME_W-1:0] rem, dq;
  logic [DCW-1:0]    dcnt;

  logic              accept, full, bad;
  logic [LW-1:0]     limit, cnt_ext;
  logic [IDX_W-1:0]  lo_in, hi_in;
  logic [XW-1:0]     mid;
  logic [TIME_W:0]   rem_sh;
  logic              rem_ge;
  logic [TIME_W-1:0] quot;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign cnt_ext = LW'(cnt);
  assign limit   = (max_entries == '0 || LW'(max_entries) > LW'(DEPTH)) ?
                   LW'(DEPTH) : LW'(max_entries);
  assign full    = cnt_ext >= limit;
  assign bad     = (opcode == OP_INVALID) || (cnt == '0) ||
                   (LW'(start_index) >= cnt_ext) || (LW'(end_index) >= cnt_ext);
  assign lo_in   = (start_index < end_index) ? start_index : end_index;
  assign hi_in   = (start_index < end_index) ? end_index : start_index;
  assign wr_en   = accept && (opcode == OP_PUSH) && !full;
  assign mid     = XW'((a + b) >> 1);
  assign rem_sh  = {rem, dq[TIME_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, step};
  assign quot    = {dq[TIME_W-2:0], rem_ge};

  // One read port: the address follows the state that issues the read.
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = it;
    unique case (state) inside
      S_IDLE: begin
        rd_en  = accept;
        rd_idx = lo_in;
      end
      S_BIN: begin
        rd_en  = 1'b1;
        rd_idx = (a + 1'b1 < b) ? IDX_W'(mid) : IDX_W'(b);
      end
      S_FWD, S_ECHK: begin
        rd_en  = 1'b1;
        rd_idx = it;
      end
      S_BWD: begin
        rd_en  = (it > lo);
        rd_idx = it - 1'b1;
      end
      S_UPD: begin
        rd_en  = 1'b1;
        rd_idx = res;
      end
      default: begin
        rd_en  = 1'b0;
        rd_idx = it;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(cnt)] <= key_time;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      max_entries <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= opcode;
            key  <= key_time;
            step <= step_time;
            lo   <= lo_in;
            hi   <= hi_in;
            a    <= XW'(lo_in);
            b    <= XW'(hi_in);
            it   <= lo_in;
            best <= lo_in;
            res  <= '0;
            if (opcode == OP_PUSH) begin
              res_st <= full ? ST_FULL : ST_PUSHED;
              if (!full) begin
                cnt <= cnt + 1'b1;
              end
              state <= S_DONE;
            end else if (bad) begin
              res_st <= ST_BAD;
              state  <= S_DONE;
            end else begin
              res_st <= ST_OK;
              unique case (opcode) inside
                OP_LO_BIN, OP_UP_BIN: state <= S_BIN;
                OP_LO_LIN, OP_UP_LIN: state <= S_FWD;
                default:              state <= (step_time == '0) ? S_FWD : S_E0W;
              endcase
            end
          end
        end
        S_BIN: begin
          state <= (a + 1'b1 < b) ? S_BINW : S_BEND;
        end
        S_BINW: begin
          if (rd_data <= key) begin
            a <= mid;
          end else begin
            b <= mid;
          end
          state <= S_BIN;
        end
        S_BEND: begin
          res   <= (rd_data == key) ? IDX_W'(b) : IDX_W'(a);
          state <= S_UPD;
        end
        S_FWD: begin
          state <= S_FWDW;
        end
        S_FWDW: begin
          if ((it < hi) && (rd_data < key)) begin
            best  <= (rd_data <= key) ? it : best;
            it    <= it + 1'b1;
            state <= S_FWD;
          end else begin
            res   <= (rd_data <= key) ? it : best;
            state <= S_UPD;
          end
        end
        S_E0W: begin
          if (key < rd_data) begin
            it    <= lo;
            state <= S_ECHK;
          end else begin
            rem   <= '0;
            dq    <= key - rd_data;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle; dq holds the
          // dividend bits still to come and the quotient bits so far.
          rem  <= rem_ge ? TIME_W'(rem_sh - {1'b0, step}) : TIME_W'(rem_sh);
          dq   <= quot;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(TIME_W - 1)) begin
            it    <= (quot > TIME_W'(hi - lo)) ? hi : lo + IDX_W'(quot);
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          state <= S_ECHKW;
        end
        S_ECHKW: begin
          if (rd_data < key) begin
            best  <= it;
            state <= S_FWD;
          end else if (rd_data > key) begin
            state <= S_BWD;
          end else begin
            res   <= it;
            state <= S_UPD;
          end
        end
        S_BWD: begin
          if (it > lo) begin
            it    <= it - 1'b1;
            state <= S_BWDW;
          end else begin
            res   <= it;
            state <= S_UPD;
          end
        end
        S_BWDW: begin
          if (rd_data > key) begin
            state <= S_BWD;
          end else begin
            res   <= it;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          // Upper-bound opcodes are the even ones.
          if (!op[0] && (LW'(res) + 1'b1 < cnt_ext)) begin
            state <= S_UPDW;
          end else begin
            state <= S_DONE;
          end
        end
        S_UPDW: begin
          if (rd_data != key) begin
            res <= res + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            found_index <= (res_st == ST_OK) ? res : '0;
            status      <= res_st;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_idx_zero, out_valid && status != ST_OK |-> found_index == '0, "index set on a non-ok result")
  `ASSERT_CLK(a_cnt_bound, LW'(cnt) <= LW'(DEPTH), "entry count beyond the store depth")
  `ASSERT_CLK(a_push_count, wr_en |=> cnt == $past(cnt) + 1'b1, "push did not advance the count")
  `ASSERT_NEVER(a_read_range, rd_en && state != S_IDLE && LW'(rd_idx) >= cnt_ext, "read of an unwritten entry")

endmodule

`default_nettype wire
